// ===== hdl/egcd_pkg.sv =====
package egcd_pkg;

    localparam int OPER_W = 31;
    localparam int COEF_W = 32;
    localparam int CNT_W  = 5;

    typedef struct packed {
        logic [OPER_W-1:0] first_operand;
        logic [OPER_W-1:0] second_operand;
    } egcd_in_t;

    typedef struct packed {
        logic [OPER_W-1:0]        divisor_result;
        logic signed [COEF_W-1:0] coef_first;
        logic signed [COEF_W-1:0] coef_second;
        logic                     coprime;
        logic                     invalid;
    } egcd_out_t;

endpackage

// ===== hdl/egcd_alu.sv =====
module egcd_alu #(
    parameter int UW = 32
) (
    input  logic [UW-1:0] a,
    input  logic [UW-1:0] b,
    input  logic          sub,
    output logic [UW-1:0] sum,
    output logic          carry
);

    logic [UW:0] total;

    // Subtract as a plus inverted b plus one; carry high means no borrow
    assign total = {1'b0, a} + {1'b0, (b ^ {UW{sub}})} + {{UW{1'b0}}, sub};
    assign sum   = total[UW-1:0];
    assign carry = total[UW];

endmodule

// ===== hdl/extended_gcd_bezout_core.sv =====
// Channel | Signals                      | Item
// op      | op_valid, op_ready, op       | egcd_in_t: two operands
// res     | res_valid, res_ready, res    | egcd_out_t: gcd, coefficients, flags
//
// An item goes straight from compare to write when an operand is zero or both are
// equal; otherwise it runs Euclid steps, each aligning the divisor and then taking
// quotient bits with remainder, s and t updates; all work runs on one shared add/subtract
// unit. op_ready is high only while no item is at work.
// A finished result waits in the output register while the next item is taken.
// rst_n clears the sequencer and the output valid asynchronously.
module extended_gcd_bezout_core #(
    parameter int WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    output logic              op_ready,
    input  egcd_pkg::egcd_in_t  op,
    output logic              res_valid,
    input  logic              res_ready,
    output egcd_pkg::egcd_out_t res
);

    import egcd_pkg::*;

    localparam int UW = (WIDTH > COEF_W) ? WIDTH : COEF_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CMP   = 4'd1;
    localparam logic [3:0] S_STEP  = 4'd2;
    localparam logic [3:0] S_ALIGN = 4'd3;
    localparam logic [3:0] S_DIVR  = 4'd4;
    localparam logic [3:0] S_DIVS  = 4'd5;
    localparam logic [3:0] S_DIVT  = 4'd6;
    localparam logic [3:0] S_FINS  = 4'd7;
    localparam logic [3:0] S_FINT  = 4'd8;
    localparam logic [3:0] S_WRITE = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [OPER_W-1:0] a_reg, b_reg;
    logic [OPER_W-1:0] r0_reg, r1_reg, rem_reg, d_reg;
    logic [WIDTH-1:0]  s0_reg, s1_reg, t0_reg, t1_reg, sacc_reg, tacc_reg;
    logic [CNT_W-1:0]  k_reg;
    logic              take_reg, swap_reg, bad_reg;
    logic              res_valid_reg;
    egcd_out_t         res_reg;

    logic [UW-1:0]     alu_a, alu_b, alu_sum;
    logic              alu_sub, alu_carry;
    logic [UW-1:0]     s0_ext, t0_ext;
    logic              res_load;

    egcd_alu #(.UW(UW)) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    assign op_ready  = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign res_load  = (state_reg == S_WRITE) && (!res_valid_reg || res_ready);

    always_comb
    begin
        alu_a   = UW'(a_reg);
        alu_b   = UW'(b_reg);
        alu_sub = 1'b1;
        case (state_reg)
            S_ALIGN:
            begin
                alu_a = UW'(rem_reg);
                alu_b = UW'({d_reg, 1'b0});
            end
            S_DIVR:
            begin
                alu_a = UW'(rem_reg);
                alu_b = UW'(d_reg);
            end
            S_DIVS:
            begin
                alu_a = UW'({sacc_reg[WIDTH-2:0], 1'b0});
                alu_b = take_reg ? UW'(s1_reg) : '0;
            end
            S_DIVT:
            begin
                alu_a = UW'({tacc_reg[WIDTH-2:0], 1'b0});
                alu_b = take_reg ? UW'(t1_reg) : '0;
            end
            S_FINS:
            begin
                alu_a   = UW'(s0_reg);
                alu_b   = UW'(sacc_reg);
                alu_sub = 1'b0;
            end
            S_FINT:
            begin
                alu_a   = UW'(t0_reg);
                alu_b   = UW'(tacc_reg);
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a   = UW'(a_reg);
                alu_b   = UW'(b_reg);
                alu_sub = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (op_valid) state_next = S_CMP;
            S_CMP:
            begin
                if (bad_reg || (alu_carry && alu_sum[OPER_W-1:0] == '0))
                    state_next = S_WRITE;
                else
                    state_next = S_STEP;
            end
            S_STEP:  state_next = S_ALIGN;
            S_ALIGN: if (!alu_carry || d_reg[OPER_W-1]) state_next = S_DIVR;
            S_DIVR:  state_next = S_DIVS;
            S_DIVS:  state_next = S_DIVT;
            S_DIVT:  state_next = (k_reg == '0) ? S_FINS : S_DIVR;
            S_FINS:  state_next = S_FINT;
            S_FINT:  state_next = (rem_reg == '0) ? S_WRITE : S_STEP;
            S_WRITE: if (res_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    a_reg   <= op.first_operand;
                    b_reg   <= op.second_operand;
                    bad_reg <= (op.first_operand == '0) || (op.second_operand == '0);
                end
            end
            S_CMP:
            begin
                swap_reg <= !alu_carry;
                r0_reg   <= alu_carry ? a_reg : b_reg;
                r1_reg   <= alu_carry ? b_reg : a_reg;
                s0_reg   <= WIDTH'(1);
                s1_reg   <= '0;
                t0_reg   <= '0;
                t1_reg   <= WIDTH'(1);
            end
            S_STEP:
            begin
                rem_reg  <= r0_reg;
                d_reg    <= r1_reg;
                k_reg    <= '0;
                sacc_reg <= '0;
                tacc_reg <= '0;
            end
            S_ALIGN:
            begin
                // Double the divisor while its double still fits under the remainder
                if (alu_carry && !d_reg[OPER_W-1])
                begin
                    d_reg <= {d_reg[OPER_W-2:0], 1'b0};
                    k_reg <= k_reg + 1'b1;
                end
            end
            S_DIVR:
            begin
                take_reg <= alu_carry;
                if (alu_carry)
                    rem_reg <= alu_sum[OPER_W-1:0];
            end
            S_DIVS:  sacc_reg <= alu_sum[WIDTH-1:0];
            S_DIVT:
            begin
                tacc_reg <= alu_sum[WIDTH-1:0];
                if (k_reg != '0)
                begin
                    k_reg <= k_reg - 1'b1;
                    d_reg <= {1'b0, d_reg[OPER_W-1:1]};
                end
            end
            S_FINS:
            begin
                s0_reg <= s1_reg;
                s1_reg <= alu_sum[WIDTH-1:0];
            end
            S_FINT:
            begin
                t0_reg <= t1_reg;
                t1_reg <= alu_sum[WIDTH-1:0];
                r0_reg <= r1_reg;
                r1_reg <= rem_reg;
            end
            default:
            begin
            end
        endcase
        if (res_load)
        begin
            res_reg.divisor_result <= bad_reg ? '0 : r0_reg;
            res_reg.coef_first     <= bad_reg ? '0 : (swap_reg ? t0_ext[COEF_W-1:0]
                                                               : s0_ext[COEF_W-1:0]);
            res_reg.coef_second    <= bad_reg ? '0 : (swap_reg ? s0_ext[COEF_W-1:0]
                                                               : t0_ext[COEF_W-1:0]);
            res_reg.coprime        <= !bad_reg && (r0_reg == OPER_W'(1));
            res_reg.invalid        <= bad_reg;
        end
    end

    assign s0_ext = UW'(s0_reg);
    assign t0_ext = UW'(t0_reg);

    a_align_fits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ALIGN |-> d_reg <= rem_reg)
        else $error("divisor aligned past remainder");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINT |-> rem_reg < r1_reg)
        else $error("remainder not below divisor at step end");

    a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STEP |-> (r1_reg != '0) && (r1_reg < r0_reg))
        else $error("Euclid step entered with bad operand order");

    a_res_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> res_valid_reg && state_reg == S_IDLE)
        else $error("result not posted after write");

endmodule
